// ===== sv/lbbc_pkg.sv =====
// Shared types and codes for the block buffer cache tag engine.
package lbbc_pkg;

   localparam int MODE_W = 3;
   localparam int DEV_W = 8;
   localparam int BLK_W = 32;
   localparam int SLOT_W = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 8;

   localparam logic [MODE_W-1:0] MODE_GET = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PIN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UNPIN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_DIRTY = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLR_DIRTY = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic               valid;
      logic [DEV_W-1:0]   dev;
      logic [BLK_W-1:0]   blk;
      logic [COUNT_W-1:0] count;
      logic               dirty;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

// ===== sv/lbbc_if.sv =====
// Request and response channel interfaces of the block buffer cache.
interface lbbc_req_if
   import lbbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [DEV_W-1:0]  device;
   logic [BLK_W-1:0]  block_number;
   logic [SLOT_W-1:0] entry;
   modport source (output valid, mode, device, block_number, entry, input ready);
   modport sink (input valid, mode, device, block_number, entry, output ready);
endinterface

interface lbbc_rsp_if
   import lbbc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   slot;
   logic                hit;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  ref_count;
   modport source (output valid, slot, hit, status, ref_count, input ready);
   modport sink (input valid, slot, hit, status, ref_count, output ready);
endinterface

// ===== sv/lbbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lbbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lru_block_buffer_cache.sv =====
// Top level of the block buffer cache tag and LRU replacement engine.
//
//   Channel  Direction  Fields
//   req_ch   in         mode, device, block_number, entry
//   rsp_ch   out        slot, hit, status, ref_count
//
// After reset a clearing pass initializes every entry of both memories; no request
// is taken during it. A get visits one slot at a time, reading the order memory,
// then the slot memory, then checking the entry: up to ENTRIES slots for the hit
// search and up to ENTRIES more for the victim scan. Other modes work on the one slot
// named by entry; a release to zero also moves that slot to the end of the order memory.
// One transaction is in flight at a time and the response holds until the sink takes it.
module lru_block_buffer_cache
   import lbbc_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  logic       clock,
   input  logic       reset,
   lbbc_req_if.sink   req_ch,
   lbbc_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] LAST_POS = IW'(ENTRIES - 1);

   typedef enum logic [3:0] {
      CLEAR, IDLE, RD_ORD, RD_SLOT, CHK, E_RD, E_CHK,
      F_RD, F_CHK, S_RD, S_WR, RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [IW-1:0]       eidx_ff, eidx_in;
   logic                miss_ff, miss_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [DEV_W-1:0]    dev_ff, dev_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                hit_ff, hit_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                slot_we;
   logic [IW-1:0]       slot_waddr, slot_raddr;
   slot_entry_type      slot_wdata, slot_rd;
   logic [ENTRY_W-1:0]  slot_rdata;
   logic                ord_we;
   logic [IW-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_rdata;

   logic [IW+SLOT_W-1:0] ent_ext;
   logic [IW+SLOT_W-1:0] cur_ext;

   assign slot_rd = slot_entry_type'(slot_rdata);
   assign ent_ext = {IW'(0), req_ch.entry};
   assign cur_ext = {SLOT_W'(0), cur_ff};

   lbbc_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   lbbc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      eidx_in = eidx_ff;
      miss_in = miss_ff;
      mode_in = mode_ff;
      dev_in = dev_ff;
      blk_in = blk_ff;
      slot_in = slot_ff;
      hit_in = hit_ff;
      status_in = status_ff;
      count_in = count_ff;
      slot_we = 1'b0;
      slot_waddr = cur_ff;
      slot_wdata = slot_rd;
      slot_raddr = eidx_ff;
      ord_we = 1'b0;
      ord_waddr = pos_ff;
      ord_wdata = eidx_ff;
      ord_raddr = pos_ff;
      case (state_ff)
         CLEAR: begin
            slot_we = 1'b1;
            slot_waddr = pos_ff;
            slot_wdata = '0;
            ord_we = 1'b1;
            ord_waddr = pos_ff;
            ord_wdata = pos_ff;
            if (pos_ff == LAST_POS) begin
               state_in = IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         IDLE: begin
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               dev_in = req_ch.device;
               blk_in = req_ch.block_number;
               eidx_in = ent_ext[IW-1:0];
               slot_in = req_ch.entry;
               hit_in = 1'b0;
               status_in = ST_OK;
               count_in = '0;
               if (req_ch.mode == MODE_GET) begin
                  pos_in = LAST_POS;
                  miss_in = 1'b0;
                  state_in = RD_ORD;
               end else if (req_ch.mode > MODE_CLR_DIRTY ||
                            32'(req_ch.entry) >= 32'(ENTRIES)) begin
                  state_in = RESP;
               end else begin
                  state_in = E_RD;
               end
            end
         end
         RD_ORD: begin
            ord_raddr = pos_ff;
            state_in = RD_SLOT;
         end
         RD_SLOT: begin
            slot_raddr = ord_rdata;
            cur_in = ord_rdata;
            state_in = CHK;
         end
         CHK: begin
            slot_in = cur_ext[SLOT_W-1:0];
            if (!miss_ff) begin
               if (slot_rd.valid && slot_rd.dev == dev_ff && slot_rd.blk == blk_ff) begin
                  hit_in = 1'b1;
                  if (slot_rd.count == COUNT_MAX) begin
                     status_in = ST_OVERFLOW;
                     count_in = COUNT_MAX;
                  end else begin
                     slot_we = 1'b1;
                     slot_wdata.count = slot_rd.count + 1'b1;
                     count_in = slot_rd.count + 1'b1;
                  end
                  state_in = RESP;
               end else if (pos_ff == '0) begin
                  miss_in = 1'b1;
                  state_in = RD_ORD;
               end else begin
                  pos_in = pos_ff - 1'b1;
                  state_in = RD_ORD;
               end
            end else begin
               if (slot_rd.count == '0 && !slot_rd.dirty) begin
                  slot_we = 1'b1;
                  slot_wdata.valid = 1'b1;
                  slot_wdata.dev = dev_ff;
                  slot_wdata.blk = blk_ff;
                  slot_wdata.count = COUNT_W'(1);
                  slot_wdata.dirty = 1'b0;
                  count_in = COUNT_W'(1);
                  state_in = RESP;
               end else if (pos_ff == LAST_POS) begin
                  slot_in = '0;
                  status_in = ST_EXHAUSTED;
                  state_in = RESP;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  state_in = RD_ORD;
               end
            end
         end
         E_RD: begin
            slot_raddr = eidx_ff;
            state_in = E_CHK;
         end
         E_CHK: begin
            slot_waddr = eidx_ff;
            count_in = slot_rd.count;
            state_in = RESP;
            case (mode_ff)
               MODE_RELEASE, MODE_UNPIN: begin
                  if (slot_rd.count == '0) begin
                     status_in = ST_ZERO;
                  end else begin
                     slot_we = 1'b1;
                     slot_wdata.count = slot_rd.count - 1'b1;
                     count_in = slot_rd.count - 1'b1;
                     if (mode_ff == MODE_RELEASE && slot_rd.count == COUNT_W'(1)) begin
                        pos_in = '0;
                        state_in = F_RD;
                     end
                  end
               end
               MODE_PIN: begin
                  if (slot_rd.count == COUNT_MAX) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     slot_we = 1'b1;
                     slot_wdata.count = slot_rd.count + 1'b1;
                     count_in = slot_rd.count + 1'b1;
                  end
               end
               MODE_SET_DIRTY: begin
                  slot_we = 1'b1;
                  slot_wdata.dirty = 1'b1;
               end
               default: begin
                  slot_we = 1'b1;
                  slot_wdata.dirty = 1'b0;
               end
            endcase
         end
         F_RD: begin
            ord_raddr = pos_ff;
            state_in = F_CHK;
         end
         F_CHK: begin
            if (ord_rdata == eidx_ff) begin
               state_in = S_RD;
            end else if (pos_ff == LAST_POS) begin
               state_in = RESP;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = F_RD;
            end
         end
         S_RD: begin
            if (pos_ff == LAST_POS) begin
               ord_we = 1'b1;
               ord_waddr = pos_ff;
               ord_wdata = eidx_ff;
               state_in = RESP;
            end else begin
               ord_raddr = pos_ff + 1'b1;
               state_in = S_WR;
            end
         end
         S_WR: begin
            ord_we = 1'b1;
            ord_waddr = pos_ff;
            ord_wdata = ord_rdata;
            pos_in = pos_ff + 1'b1;
            state_in = S_RD;
         end
         RESP: begin
            if (rsp_ch.ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
      end
      cur_ff <= cur_in;
      eidx_ff <= eidx_in;
      miss_ff <= miss_in;
      mode_ff <= mode_in;
      dev_ff <= dev_in;
      blk_ff <= blk_in;
      slot_ff <= slot_in;
      hit_ff <= hit_in;
      status_ff <= status_in;
      count_ff <= count_in;
   end

   assign req_ch.ready = (state_ff == IDLE);
   assign rsp_ch.valid = (state_ff == RESP);
   assign rsp_ch.slot = slot_ff;
   assign rsp_ch.hit = hit_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.ref_count = count_ff;

endmodule

// ===== tb/lbbc_test_if.sv =====
// Transaction type used by the cache test.
package lbbc_test_pkg;
   import lbbc_pkg::*;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  ref_count;
   } cache_rsp_type;
endpackage

// ===== tb/lru_block_buffer_cache_test.sv =====
// Random and directed test of the block buffer cache tag engine against its own cache model.
module lru_block_buffer_cache_test;
   import lbbc_pkg::*;
   import lbbc_test_pkg::*;

   localparam int NSLOT = 32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors = 0;
   bit stim_done = 1'b0;

   lbbc_req_if req_ch ();
   lbbc_rsp_if rsp_ch ();

   lru_block_buffer_cache #(.ENTRIES(NSLOT)) DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   class cache_scoreboard;
      logic [DEV_W-1:0]   dev_tag[NSLOT];
      logic [BLK_W-1:0]   blk_tag[NSLOT];
      bit                 tag_valid[NSLOT];
      logic [COUNT_W-1:0] count[NSLOT];
      bit                 dirty[NSLOT];
      int                 order[NSLOT];
      cache_rsp_type      pending[$];

      function new();
         for (int i = 0; i < NSLOT; i++) begin
            dev_tag[i] = '0; blk_tag[i] = '0; tag_valid[i] = 0;
            count[i] = '0; dirty[i] = 0; order[i] = i;
         end
      endfunction

      function void note_request(input logic [MODE_W-1:0] mode, input logic [DEV_W-1:0] dv,
                                 input logic [BLK_W-1:0] bn, input logic [SLOT_W-1:0] e);
         cache_rsp_type r;
         int s;
         int p;
         r = '{slot: e, hit: 1'b0, status: ST_OK, ref_count: '0};
         if (mode == MODE_GET) begin
            for (p = NSLOT - 1; p >= 0; p--) begin
               s = order[p];
               if (tag_valid[s] && dev_tag[s] == dv && blk_tag[s] == bn) break;
            end
            if (p >= 0) begin
               r.slot = SLOT_W'(s); r.hit = 1'b1;
               if (count[s] == COUNT_MAX) r.status = ST_OVERFLOW;
               else count[s]++;
               r.ref_count = count[s];
            end else begin
               for (p = 0; p < NSLOT; p++) begin
                  s = order[p];
                  if (count[s] == 0 && !dirty[s]) break;
               end
               if (p < NSLOT) begin
                  dev_tag[s] = dv; blk_tag[s] = bn; tag_valid[s] = 1;
                  count[s] = COUNT_W'(1); r.slot = SLOT_W'(s); r.ref_count = COUNT_W'(1);
               end else begin
                  r.slot = '0; r.status = ST_EXHAUSTED;
               end
            end
         end else if (mode <= MODE_CLR_DIRTY && e < NSLOT) begin
            case (mode)
               MODE_RELEASE, MODE_UNPIN: begin
                  if (count[e] == 0) r.status = ST_ZERO;
                  else begin
                     count[e]--;
                     if (mode == MODE_RELEASE && count[e] == 0) begin
                        for (p = 0; order[p] != e; p++);
                        for (; p < NSLOT - 1; p++) order[p] = order[p + 1];
                        order[NSLOT - 1] = e;
                     end
                  end
               end
               MODE_PIN: begin
                  if (count[e] == COUNT_MAX) r.status = ST_OVERFLOW;
                  else count[e]++;
               end
               MODE_SET_DIRTY: dirty[e] = 1;
               default: dirty[e] = 0;
            endcase
            r.ref_count = count[e];
         end
         pending.push_back(r);
      endfunction

      task check_response(input cache_rsp_type got);
         cache_rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected transaction slot", got.slot, -1);
            return;
         end
         want = pending.pop_front();
         if (got.slot !== want.slot) report("slot", got.slot, want.slot);
         if (got.hit !== want.hit) report("hit", got.hit, want.hit);
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.ref_count !== want.ref_count)
            report("ref_count", got.ref_count, want.ref_count);
      endtask
   endclass

   cache_scoreboard sb = new();

   initial begin
      req_ch.valid = 1'b0; req_ch.mode = MODE_GET; req_ch.device = '0;
      req_ch.block_number = '0; req_ch.entry = '0; rsp_ch.ready = 1'b0;
   end

   // Accepted requests are noted in the scoreboard at the accepting edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.mode, req_ch.device, req_ch.block_number, req_ch.entry);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response('{rsp_ch.slot, rsp_ch.hit, rsp_ch.status, rsp_ch.ref_count});
   end

   // The receiver stalls in a pattern of runs, with quiet stretches.
   int stall_left = 0;
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if ((stall_phase % 400) < 150 || $urandom_range(3) != 0) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         stall_left <= $urandom_range(12);
         rsp_ch.ready <= 1'b0;
      end
   end

   task automatic send(input logic [MODE_W-1:0] m, input logic [DEV_W-1:0] dv,
                       input logic [BLK_W-1:0] bn, input logic [SLOT_W-1:0] e);
      req_ch.valid <= 1'b1; req_ch.mode <= m; req_ch.device <= dv;
      req_ch.block_number <= bn; req_ch.entry <= e;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pause(input int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   int burst;
   logic [DEV_W-1:0] hot_dev[8];
   logic [BLK_W-1:0] hot_blk[8];
   int pick;
   int k;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, overflow, zero count, bad modes, exhaustion.
      send(MODE_RELEASE, 8'h00, 32'h0, 5'd0);
      send(MODE_UNPIN, 8'h00, 32'h0, 5'd31);
      send(MODE_GET, 8'hFF, 32'hFFFFFFFF, 5'd0);
      send(MODE_GET, 8'h00, 32'h00000000, 5'd31);
      send(MODE_GET, 8'hFF, 32'hFFFFFFFF, 5'd0);
      send(3'd6, 8'hA5, 32'h5A5A5A5A, 5'd31);
      send(3'd7, 8'h5A, 32'hA5A5A5A5, 5'd21);
      send(MODE_SET_DIRTY, 8'h0, 32'h0, 5'd2);
      send(MODE_GET, 8'h12, 32'h1234, 5'd0);
      send(MODE_CLR_DIRTY, 8'h0, 32'h0, 5'd2);
      send(MODE_PIN, 8'h0, 32'h0, 5'd1);
      send(MODE_UNPIN, 8'h0, 32'h0, 5'd1);
      send(MODE_UNPIN, 8'h0, 32'h0, 5'd1);
      send(MODE_RELEASE, 8'h0, 32'h0, 5'd0);
      for (k = 0; k < 256; k++) send(MODE_PIN, 8'h0, 32'h0, 5'd5);
      send(MODE_GET, 8'h0, 32'h0, 5'd0);
      pause(3);
      for (k = 0; k < 33; k++) send(MODE_GET, 8'h40, BLK_W'(k), 5'd0);
      for (k = 0; k < 32; k++) send(MODE_RELEASE, 8'h0, 32'h0, SLOT_W'(k));
      pause(2);
      for (k = 0; k < 8; k++) begin
         hot_dev[k] = DEV_W'($urandom); hot_blk[k] = BLK_W'($urandom);
      end
      k = 0;
      while (k < 215) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            pick = $urandom_range(99);
            if (pick < 40)
               send(MODE_GET, hot_dev[$urandom_range(7)], hot_blk[$urandom_range(7)],
                    SLOT_W'($urandom));
            else if (pick < 50)
               send(MODE_GET, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom));
            else if (pick < 70)
               send(MODE_RELEASE, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom));
            else if (pick < 78)
               send(MODE_PIN, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom));
            else if (pick < 85)
               send(MODE_UNPIN, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom));
            else if (pick < 90)
               send(MODE_SET_DIRTY, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom));
            else if (pick < 97)
               send(MODE_CLR_DIRTY, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom));
            else
               send(MODE_W'($urandom_range(6, 7)), DEV_W'($urandom), BLK_W'($urandom),
                    SLOT_W'($urandom));
            k++;
         end
         if ((k % 200) < 120) pause($urandom_range(0, 9));
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
